// ===== hw/rtl/screen_quad_from_euler_angles_macros.svh =====
// Assertion helpers for the screen quad block.
`ifndef SCREEN_QUAD_FROM_EULER_ANGLES_MACROS_SVH
`define SCREEN_QUAD_FROM_EULER_ANGLES_MACROS_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define SCQE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SCQE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCQE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCQE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/scqe_pkg.sv =====
`timescale 1ns / 1ps
package scqe_pkg;

    localparam int ANG_W = 15;
    localparam int DIM_W = 16;
    localparam int POS_W = 24;
    localparam int VTX_W = 3;
    localparam int ROM_W = 15;

    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam int ROUND_BIAS   = QUARTER_TURN / 2;

    // QUARTER_TURN = 128 * 45: shift by 7, then divide by 45 via reciprocal
    localparam int DIV_SHIFT   = 7;
    localparam int DIV_REM     = 45;
    localparam int RECIP45     = 372827;   // floor(2^24 / 45)
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 24;

    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam int unsigned TAYLOR_DIV [12] = '{
        6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600
    };

    localparam logic [VTX_W-1:0] VTX_LAST = 3'd5;

endpackage

// ===== hw/rtl/screen_quad_from_euler_angles.sv =====
`timescale 1ns / 1ps
// Screen quad from Euler angles.
// Input channel: push/full. A layout (yaw, pitch, roll in 1/64 degree, distance,
// width and height in Q8.8 metres) is taken at an edge with push high, full low.
// Result channel: empty/pop. Each layout yields six vertices (BL, BR, TR, BL,
// TR, TL) with Q16.8 position, 0/1 texture coordinates, index 0..5 and a
// last flag on the sixth. A vertex is taken at an edge with pop high, empty low.
// The emitter puts out one vertex per cycle while the output queue is not full;
// the angle and basis stages in front of it run in parallel, so a new layout
// can move up through them while the emitter is busy with the last one.
// Angle reduction runs in the front stage; a two-entry queue separates it from
// the sine ROM read, basis, roll and scaling stages.
// Reset clears all queues and stage valids; no item is lost or made up.
// When the receiver stalls, the output queue fills, the emitter holds its
// vertex, the stages behind it back up, and full rises.
module screen_quad_from_euler_angles #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [scqe_pkg::ANG_W-1:0]   i_yaw_angle,
    input  logic signed [scqe_pkg::ANG_W-1:0]   i_pitch_angle,
    input  logic signed [scqe_pkg::ANG_W-1:0]   i_roll_angle,
    input  logic [scqe_pkg::DIM_W-1:0]          i_view_distance,
    input  logic [scqe_pkg::DIM_W-1:0]          i_screen_width,
    input  logic [scqe_pkg::DIM_W-1:0]          i_screen_height,
    output logic                                empty,
    input  logic                                pop,
    output logic [scqe_pkg::VTX_W-1:0]          o_vertex_index,
    output logic signed [scqe_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [scqe_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [scqe_pkg::POS_W-1:0]   o_pos_z,
    output logic                                o_tex_u,
    output logic                                o_tex_v,
    output logic                                o_last_vertex
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int JW = 6 * (AW + 1) + 3 * scqe_pkg::DIM_W;
    localparam int OW = scqe_pkg::VTX_W + 3 * scqe_pkg::POS_W + 3;
    localparam int PS = scqe_pkg::POS_W;

    logic          s_jpush, s_jfull, s_jempty, s_jpop;
    logic [JW-1:0] s_jin, s_jout;
    logic          s_opush, s_ofull;
    logic [OW-1:0] s_oin, s_oout;

    scqe_front #(.DEPTH(SINE_TABLE_DEPTH)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_yaw_angle     (i_yaw_angle),
        .i_pitch_angle   (i_pitch_angle),
        .i_roll_angle    (i_roll_angle),
        .i_view_distance (i_view_distance),
        .i_screen_width  (i_screen_width),
        .i_screen_height (i_screen_height),
        .o_qpush         (s_jpush),
        .o_qdata         (s_jin),
        .i_qfull         (s_jfull)
    );

    scqe_queue #(.W(JW), .DEPTH(2)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_jpush),
        .i_data  (s_jin),
        .o_full  (s_jfull),
        .i_pop   (s_jpop),
        .o_empty (s_jempty),
        .o_data  (s_jout)
    );

    scqe_back #(.DEPTH(SINE_TABLE_DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qempty (s_jempty),
        .i_qdata  (s_jout),
        .o_qpop   (s_jpop),
        .o_opush  (s_opush),
        .o_odata  (s_oin),
        .i_ofull  (s_ofull)
    );

    scqe_queue #(.W(OW), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_opush),
        .i_data  (s_oin),
        .o_full  (s_ofull),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (s_oout)
    );

    assign o_vertex_index = s_oout[OW-1 -: scqe_pkg::VTX_W];
    assign o_pos_x        = s_oout[3 + 2*PS +: PS];
    assign o_pos_y        = s_oout[3 + PS +: PS];
    assign o_pos_z        = s_oout[3 +: PS];
    assign o_tex_u        = s_oout[2];
    assign o_tex_v        = s_oout[1];
    assign o_last_vertex  = s_oout[0];

endmodule

// ===== hw/rtl/scqe_sin_rom.sv =====
`timescale 1ns / 1ps
module scqe_sin_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [$clog2(DEPTH+1)-1:0]     i_addr_a,
    input  logic [$clog2(DEPTH+1)-1:0]     i_addr_b,
    output logic [scqe_pkg::ROM_W-1:0]     o_data_a,
    output logic [scqe_pkg::ROM_W-1:0]     o_data_b
);

    typedef logic [scqe_pkg::ROM_W-1:0] t_rom [0:DEPTH];

    // quarter-wave sine in Q14, Taylor series evaluated in Q30
    function automatic t_rom build_rom();
        t_rom              t;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint            v;
        for (int k = 0; k <= DEPTH; k++) begin
            x    = longint'(scqe_pkg::HALF_PI_Q30 * k) / DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / scqe_pkg::TAYLOR_DIV[n-1];
                if ((n & 1) == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            v = (sum * 16384 + (longint'(1) << 29)) >>> 30;
            if (v > 16384) v = 16384;
            t[k] = scqe_pkg::ROM_W'(v);
        end
        return t;
    endfunction

    localparam t_rom ROM = build_rom();

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data_a <= ROM[i_addr_a];
            o_data_b <= ROM[i_addr_b];
        end
    end

endmodule

// ===== hw/rtl/scqe_queue.sv =====
`timescale 1ns / 1ps
module scqe_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          s_wr, s_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign s_wr    = i_push && !o_full;
    assign s_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_wr) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (s_rd) r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            if (s_wr && !s_rd) r_cnt <= r_cnt + CW'(1);
            else if (s_rd && !s_wr) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== hw/rtl/scqe_front.sv =====
`timescale 1ns / 1ps
module scqe_front #(
    parameter int DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic signed [scqe_pkg::ANG_W-1:0]   i_yaw_angle,
    input  logic signed [scqe_pkg::ANG_W-1:0]   i_pitch_angle,
    input  logic signed [scqe_pkg::ANG_W-1:0]   i_roll_angle,
    input  logic [scqe_pkg::DIM_W-1:0]          i_view_distance,
    input  logic [scqe_pkg::DIM_W-1:0]          i_screen_width,
    input  logic [scqe_pkg::DIM_W-1:0]          i_screen_height,
    output logic                                o_qpush,
    output logic [6*($clog2(DEPTH+1)+1)+3*scqe_pkg::DIM_W-1:0] o_qdata,
    input  logic                                i_qfull
);

    localparam int AW = $clog2(DEPTH + 1);
    localparam int RW = 13;                       // remainder within a quarter
    localparam int XW = RW + AW;
    localparam int YW = XW - scqe_pkg::DIV_SHIFT;
    localparam int PW = YW + scqe_pkg::RECIP_W;
    localparam int DW = 3 * scqe_pkg::DIM_W;

    logic signed [scqe_pkg::ANG_W-1:0] s_ang [3];
    logic [YW-1:0] n_y [6];
    logic [PW-1:0] n_p [6];
    logic [1:0]    n_q [6];
    logic [YW-1:0] r_y [6];
    logic [PW-1:0] r_p [6];
    logic [1:0]    r_q [6];
    logic [DW-1:0] r_dims;
    logic          r_v;
    logic          s_ready;

    assign s_ang[0] = i_yaw_angle;
    assign s_ang[1] = i_pitch_angle;
    assign s_ang[2] = i_roll_angle;

    // lanes: sin yaw, cos yaw, sin pitch, cos pitch, sin roll, cos roll
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            logic signed [15:0] a16;
            logic [14:0]        m;
            logic [1:0]         q;
            logic [RW-1:0]      r;
            logic [XW-1:0]      x;
            a16 = 16'(s_ang[j/2]);
            if ((j % 2) == 1) a16 = a16 + 16'(scqe_pkg::QUARTER_TURN);
            m = a16[15] ? 15'(a16 + 16'(scqe_pkg::FULL_TURN)) : a16[14:0];
            priority if (m >= 15'(3 * scqe_pkg::QUARTER_TURN)) q = 2'd3;
            else if (m >= 15'(2 * scqe_pkg::QUARTER_TURN)) q = 2'd2;
            else if (m >= 15'(scqe_pkg::QUARTER_TURN)) q = 2'd1;
            else q = 2'd0;
            r = RW'(m - 15'(q) * 15'(scqe_pkg::QUARTER_TURN));
            x = XW'(r) * XW'(DEPTH) + XW'(scqe_pkg::ROUND_BIAS);
            n_y[j] = x[XW-1:scqe_pkg::DIV_SHIFT];
            n_p[j] = PW'(n_y[j]) * PW'(scqe_pkg::RECIP45);
            n_q[j] = q;
        end
    end

    assign s_ready = !r_v || !i_qfull;
    assign o_full  = !s_ready;
    assign o_qpush = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= 1'b0;
        else if (s_ready) r_v <= i_push;
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_push) begin
            for (int j = 0; j < 6; j++) begin
                r_y[j] <= n_y[j];
                r_p[j] <= n_p[j];
                r_q[j] <= n_q[j];
            end
            r_dims <= {i_view_distance, i_screen_width, i_screen_height};
        end
    end

    // reciprocal quotient can come out one low; one compare fixes it
    always_comb begin
        o_qdata[DW-1:0] = r_dims;
        for (int j = 0; j < 6; j++) begin
            logic [AW-1:0] q0;
            logic [YW-1:0] q45;
            logic [YW-1:0] diff;
            logic [AW-1:0] idx;
            q0   = r_p[j][scqe_pkg::RECIP_SHIFT +: AW];
            q45  = YW'(q0) * YW'(scqe_pkg::DIV_REM);
            diff = r_y[j] - q45;
            idx  = (diff >= YW'(scqe_pkg::DIV_REM)) ? q0 + AW'(1) : q0;
            o_qdata[DW + j*(AW+1) +: AW+1] =
                {r_q[j][1], (r_q[j][0] ? AW'(DEPTH) - idx : idx)};
        end
    end

endmodule

// ===== hw/rtl/scqe_back.sv =====
`timescale 1ns / 1ps
`include "screen_quad_from_euler_angles_macros.svh"
module scqe_back #(
    parameter int DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_qempty,
    input  logic [6*($clog2(DEPTH+1)+1)+3*scqe_pkg::DIM_W-1:0] i_qdata,
    output logic                                o_qpop,
    output logic                                o_opush,
    output logic [scqe_pkg::VTX_W+3*scqe_pkg::POS_W+2:0] o_odata,
    input  logic                                i_ofull
);

    localparam int AW = $clog2(DEPTH + 1);
    localparam int DM = scqe_pkg::DIM_W;
    localparam int DW = 3 * DM;

    function automatic logic signed [16:0] mul14(logic signed [16:0] a,
                                                 logic signed [16:0] b);
        logic signed [33:0] p;
        p = 34'(a) * 34'(b) + 34'sd8192;
        return p[30:14];
    endfunction

    // ROM stage (A)
    logic [scqe_pkg::ROM_W-1:0] s_rom [6];
    logic [5:0]    r_neg_a;
    logic [DW-1:0] r_dims_a, r_dims_b, r_dims_c;
    logic          r_va, r_vb, r_vc, r_ve;
    logic          s_a_ready, s_b_ready, s_c_ready, s_e_ready, s_e_done;
    logic signed [16:0] s_t [6];

    assign o_qpop = !i_qempty && s_a_ready;

    for (genvar g = 0; g < 3; g++) begin : g_rom
        scqe_sin_rom #(.DEPTH(DEPTH)) u_rom (
            .i_clk    (i_clk),
            .i_en     (o_qpop),
            .i_addr_a (i_qdata[DW + (2*g)*(AW+1) +: AW]),
            .i_addr_b (i_qdata[DW + (2*g+1)*(AW+1) +: AW]),
            .o_data_a (s_rom[2*g]),
            .o_data_b (s_rom[2*g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (o_qpop) begin
            for (int j = 0; j < 6; j++) r_neg_a[j] <= i_qdata[DW + j*(AW+1) + AW];
            r_dims_a <= i_qdata[DW-1:0];
        end
    end

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            s_t[j] = r_neg_a[j] ? -$signed({2'b00, s_rom[j]}) : $signed({2'b00, s_rom[j]});
        end
    end

    // basis stage (B): 0 sy, 1 cy, 2 sp, 3 cp, 4 sr, 5 cr
    logic signed [16:0] r_fw_b [3];
    logic signed [16:0] r_br [3];
    logic signed [16:0] r_bu [3];
    logic signed [16:0] r_cr, r_sr, r_nsr;

    always_ff @(posedge i_clk) begin
        if (s_b_ready) begin
            r_fw_b[0] <= mul14(s_t[0], s_t[3]);
            r_fw_b[1] <= s_t[2];
            r_fw_b[2] <= mul14(s_t[1], s_t[3]);
            r_br[0]   <= s_t[1];
            r_br[1]   <= '0;
            r_br[2]   <= -s_t[0];
            r_bu[0]   <= -mul14(s_t[0], s_t[2]);
            r_bu[1]   <= s_t[3];
            r_bu[2]   <= -mul14(s_t[1], s_t[2]);
            r_cr      <= s_t[5];
            r_sr      <= s_t[4];
            r_nsr     <= -s_t[4];
            r_dims_b  <= r_dims_a;
        end
    end

    // roll stage (C)
    logic signed [16:0] r_fw_c [3];
    logic signed [17:0] r_rt [3];
    logic signed [17:0] r_up [3];

    always_ff @(posedge i_clk) begin
        if (s_c_ready) begin
            for (int i = 0; i < 3; i++) begin
                r_rt[i]   <= 18'(mul14(r_br[i], r_cr)) + 18'(mul14(r_bu[i], r_sr));
                r_up[i]   <= 18'(mul14(r_bu[i], r_cr)) + 18'(mul14(r_br[i], r_nsr));
                r_fw_c[i] <= r_fw_b[i];
            end
            r_dims_c <= r_dims_b;
        end
    end

    // emitter stage (E): scaled vectors held while six vertices go out
    logic signed [34:0] r_ce [3];
    logic signed [34:0] r_hz [3];
    logic signed [34:0] r_vt [3];
    logic [scqe_pkg::VTX_W-1:0] r_k;
    logic signed [16:0] s_dist, s_wid, s_hei;

    assign s_dist = $signed({1'b0, r_dims_c[2*DM +: DM]});
    assign s_wid  = $signed({1'b0, r_dims_c[DM +: DM]});
    assign s_hei  = $signed({1'b0, r_dims_c[0 +: DM]});

    always_ff @(posedge i_clk) begin
        if (s_e_ready && r_vc) begin
            for (int i = 0; i < 3; i++) begin
                r_ce[i] <= 35'(34'(r_fw_c[i]) * 34'(s_dist)) <<< 1;
                r_hz[i] <= 35'(r_rt[i]) * 35'(s_wid);
                r_vt[i] <= 35'(r_up[i]) * 35'(s_hei);
            end
        end
    end

    assign s_e_done  = r_ve && !i_ofull && (r_k == scqe_pkg::VTX_LAST);
    assign s_e_ready = !r_ve || s_e_done;
    assign s_c_ready = !r_vc || s_e_ready;
    assign s_b_ready = !r_vb || s_c_ready;
    assign s_a_ready = !r_va || s_b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_ve <= 1'b0;
            r_k  <= '0;
        end else begin
            if (s_a_ready) r_va <= !i_qempty;
            if (s_b_ready) r_vb <= r_va;
            if (s_c_ready) r_vc <= r_vb;
            if (s_e_ready) begin
                r_ve <= r_vc;
                r_k  <= '0;
            end else if (r_ve && !i_ofull) begin
                r_k <= r_k + scqe_pkg::VTX_W'(1);
            end
        end
    end

    // vertex order BL, BR, TR, BL, TR, TL
    logic s_hpos, s_vpos, s_u, s_v;
    always_comb begin
        unique case (r_k)
            3'd0:    begin s_hpos = 1'b0; s_vpos = 1'b0; s_u = 1'b0; s_v = 1'b1; end
            3'd1:    begin s_hpos = 1'b1; s_vpos = 1'b0; s_u = 1'b1; s_v = 1'b1; end
            3'd2:    begin s_hpos = 1'b1; s_vpos = 1'b1; s_u = 1'b1; s_v = 1'b0; end
            3'd3:    begin s_hpos = 1'b0; s_vpos = 1'b0; s_u = 1'b0; s_v = 1'b1; end
            3'd4:    begin s_hpos = 1'b1; s_vpos = 1'b1; s_u = 1'b1; s_v = 1'b0; end
            3'd5:    begin s_hpos = 1'b0; s_vpos = 1'b1; s_u = 1'b0; s_v = 1'b0; end
            default: begin s_hpos = 1'b0; s_vpos = 1'b0; s_u = 1'b0; s_v = 1'b0; end
        endcase
    end

    // sums stay within +/-2^36, so the 37-bit sum cannot overflow and bits 36:15 hold the rounded value
    logic [scqe_pkg::POS_W-1:0] s_pos [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [36:0] s;
            s = 37'(r_ce[i])
              + (s_hpos ? 37'(r_hz[i]) : -37'(r_hz[i]))
              + (s_vpos ? 37'(r_vt[i]) : -37'(r_vt[i]))
              + 37'sd16384;
            s_pos[i] = scqe_pkg::POS_W'($signed(s[36:15]));
        end
    end

    assign o_opush = r_ve;
    assign o_odata = {r_k, s_pos[0], s_pos[1], s_pos[2], s_u, s_v,
                      (r_k == scqe_pkg::VTX_LAST)};

    `SCQE_ASSERT(a_k_range, i_clk, i_rst_n, r_ve |-> (r_k <= scqe_pkg::VTX_LAST), "vertex count out of range")
    `SCQE_ASSERT(a_k_restart, i_clk, i_rst_n, (r_vc && s_e_ready) |=> (r_ve && r_k == '0), "new item did not start at first vertex")
    `SCQE_ASSERT(a_done_drops, i_clk, i_rst_n, (s_e_done && !r_vc) |=> !r_ve, "emitter stayed busy after last vertex")
    `SCQE_ASSERT(a_hold_on_full, i_clk, i_rst_n, (r_ve && i_ofull) |=> (r_ve && $stable(r_k)), "emitter moved while output full")
    `SCQE_ASSERT_ALWAYS(a_reset_idle, i_clk, (!i_rst_n) |=> (!r_ve && !r_va), "pipeline not idle after reset")

endmodule

// ===== tb/screen_quad_from_euler_angles_tb.sv =====
`timescale 1ns / 1ps
module screen_quad_from_euler_angles_tb;

    localparam int DEPTH = 1024;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [scqe_pkg::VTX_W-1:0] idx;
        logic [scqe_pkg::POS_W-1:0] x;
        logic [scqe_pkg::POS_W-1:0] y;
        logic [scqe_pkg::POS_W-1:0] z;
        logic u;
        logic v;
        logic last;
    } t_vertex;

    typedef struct {
        logic [scqe_pkg::ANG_W-1:0] yaw;
        logic [scqe_pkg::ANG_W-1:0] pitch;
        logic [scqe_pkg::ANG_W-1:0] roll;
        logic [scqe_pkg::DIM_W-1:0] view_dist;
        logic [scqe_pkg::DIM_W-1:0] wid;
        logic [scqe_pkg::DIM_W-1:0] hei;
        bit fixed;          // expected vertices typed in below
        logic [scqe_pkg::POS_W-1:0] px;
        logic [scqe_pkg::POS_W-1:0] py;
        logic [scqe_pkg::POS_W-1:0] pz;
    } t_layout_row;

    logic i_clk, i_rst_n;
    logic push, full, empty, pop;
    logic [scqe_pkg::ANG_W-1:0] i_yaw_angle, i_pitch_angle, i_roll_angle;
    logic [scqe_pkg::DIM_W-1:0] i_view_distance, i_screen_width, i_screen_height;
    logic [scqe_pkg::VTX_W-1:0] o_vertex_index;
    logic [scqe_pkg::POS_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic o_tex_u, o_tex_v, o_last_vertex;

    screen_quad_from_euler_angles dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_yaw_angle(i_yaw_angle), .i_pitch_angle(i_pitch_angle),
        .i_roll_angle(i_roll_angle), .i_view_distance(i_view_distance),
        .i_screen_width(i_screen_width), .i_screen_height(i_screen_height),
        .empty(empty), .pop(pop), .o_vertex_index(o_vertex_index),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_tex_u(o_tex_u), .o_tex_v(o_tex_v), .o_last_vertex(o_last_vertex)
    );

    longint sine_rom [DEPTH+1];
    t_vertex vertex_queue [$];
    t_layout_row layouts [$];
    int errors = 0;
    int vertices_seen = 0;
    int layouts_sent = 0;
    int cycles = 0;
    bit calm = 0;       // no idling on either side
    bit send_done = 0;

    function automatic longint rshift_round(longint val, int s);
        longint t;
        t = val + (longint'(1) <<< (s - 1));
        if (t >= 0) return t >>> s;
        return -(((-t) + (longint'(1) <<< s) - 1) >>> s);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return rshift_round(a * b, 14);
    endfunction

    function automatic longint sine_lookup(int ang);
        int m, q;
        longint r, i, val;
        m = ang % scqe_pkg::FULL_TURN;
        if (m < 0) m += scqe_pkg::FULL_TURN;
        q = m / scqe_pkg::QUARTER_TURN;
        r = m % scqe_pkg::QUARTER_TURN;
        i = (r * DEPTH + scqe_pkg::QUARTER_TURN / 2) / scqe_pkg::QUARTER_TURN;
        if (i > DEPTH) i = DEPTH;
        val = (q & 1) ? sine_rom[DEPTH - i] : sine_rom[i];
        return (q & 2) ? -val : val;
    endfunction

    function automatic logic [scqe_pkg::POS_W-1:0] to_pos(longint q23);
        longint p;
        p = rshift_round(q23, 15);
        if (p > 8388607) p = 8388607;
        if (p < -8388608) p = -8388608;
        return p[scqe_pkg::POS_W-1:0];
    endfunction

    task automatic fill_sine_rom();
        longint unsigned x, x2, term;
        longint sum, val;
        for (int k = 0; k <= DEPTH; k++) begin
            x = (scqe_pkg::HALF_PI_Q30 * k) / DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n & 1) sum -= term;
                else sum += term;
            end
            if (sum < 0) sum = 0;
            val = (sum * 16384 + (longint'(1) <<< 29)) >>> 30;
            if (val > 16384) val = 16384;
            sine_rom[k] = val;
        end
    endtask

    task automatic predict_quad(t_layout_row L);
        int ya, pa, ra;
        longint sy, cy, sp, cp, sr, cr, rt, upv, s;
        longint fw[3], br[3], bu[3], ce[3], hz[3], vt[3];
        logic [scqe_pkg::POS_W-1:0] pos[3];
        int hs[6] = '{-1, 1, 1, -1, 1, -1};
        int vs[6] = '{-1, -1, 1, -1, 1, 1};
        t_vertex vx;
        ya = $signed(L.yaw);
        pa = $signed(L.pitch);
        ra = $signed(L.roll);
        sy = sine_lookup(ya); cy = sine_lookup(ya + scqe_pkg::QUARTER_TURN);
        sp = sine_lookup(pa); cp = sine_lookup(pa + scqe_pkg::QUARTER_TURN);
        sr = sine_lookup(ra); cr = sine_lookup(ra + scqe_pkg::QUARTER_TURN);
        fw = '{qmul(sy, cp), sp, qmul(cy, cp)};
        br = '{cy, 0, -sy};
        bu = '{-qmul(sy, sp), cp, -qmul(cy, sp)};
        for (int i = 0; i < 3; i++) begin
            rt = qmul(br[i], cr) + qmul(bu[i], sr);
            upv = qmul(bu[i], cr) + qmul(br[i], -sr);
            ce[i] = 2 * fw[i] * longint'(L.view_dist);
            hz[i] = rt * longint'(L.wid);
            vt[i] = upv * longint'(L.hei);
        end
        for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < 3; i++) begin
                s = ce[i] + hs[k] * hz[i] + vs[k] * vt[i];
                pos[i] = to_pos(s);
            end
            vx.idx = scqe_pkg::VTX_W'(k);
            if (L.fixed) begin
                vx.x = L.px; vx.y = L.py; vx.z = L.pz;
            end else begin
                vx.x = pos[0]; vx.y = pos[1]; vx.z = pos[2];
            end
            vx.u = (hs[k] > 0);
            vx.v = (vs[k] < 0);
            vx.last = (k == 5);
            vertex_queue.push_back(vx);
        end
    endtask

    function automatic t_layout_row row(int y, int p, int r, int d, int w, int h);
        t_layout_row L;
        L.yaw = scqe_pkg::ANG_W'(y);
        L.pitch = scqe_pkg::ANG_W'(p);
        L.roll = scqe_pkg::ANG_W'(r);
        L.view_dist = scqe_pkg::DIM_W'(d);
        L.wid = scqe_pkg::DIM_W'(w);
        L.hei = scqe_pkg::DIM_W'(h);
        L.fixed = 0; L.px = '0; L.py = '0; L.pz = '0;
        return L;
    endfunction

    function automatic t_layout_row row_fixed(int y, int p, int r, int d,
                                              int px, int py, int pz);
        t_layout_row L;
        L = row(y, p, r, d, 0, 0);
        L.fixed = 1;
        L.px = scqe_pkg::POS_W'(px);
        L.py = scqe_pkg::POS_W'(py);
        L.pz = scqe_pkg::POS_W'(pz);
        return L;
    endfunction

    function automatic int rand_angle();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 32767) - 16384;     // beyond a half turn
            1: return 1440 * ($urandom_range(0, 16) - 8);   // multiples of 22.5 deg
            default: return $urandom_range(0, 23040) - 11520;
        endcase
    endfunction

    function automatic int rand_dim();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 16'hFFFF;
            2: return $urandom_range(0, 65535);
            default: return $urandom_range(0, 2048);
        endcase
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // directed layouts; zero size collapses all six vertices onto the centre
    initial begin
        layouts.push_back(row_fixed(0, 0, 0, 256, 0, 0, 256));
        layouts.push_back(row_fixed(0, 0, 0, 0, 0, 0, 0));
        layouts.push_back(row_fixed(0, 0, 0, 16'hFFFF, 0, 0, 65535));
        layouts.push_back(row_fixed(11520, 0, 0, 256, 0, 0, -256));
        layouts.push_back(row_fixed(-11520, 0, 0, 256, 0, 0, -256));
        layouts.push_back(row_fixed(5760, 0, 0, 256, 256, 0, 0));
        layouts.push_back(row_fixed(0, 5760, 0, 256, 0, 256, 0));
        layouts.push_back(row_fixed(0, -5760, 0, 256, 0, -256, 0));
        layouts.push_back(row_fixed(-5760, 0, 0, 256, -256, 0, 0));
        layouts.push_back(row(0, 0, 0, 256, 512, 256));
        layouts.push_back(row(0, 0, 5760, 256, 512, 256));
        layouts.push_back(row(0, 0, -11520, 0, 16'hFFFF, 16'hFFFF));
        layouts.push_back(row(16383, -16384, 16383, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        layouts.push_back(row(-16384, 16383, -16384, 0, 16'hFFFF, 0));
        layouts.push_back(row(2880, 1440, 720, 512, 0, 1024));
        layouts.push_back(row(-1, 1, -2, 100, 200, 300));
        layouts.push_back(row(15'h5555, 15'h2AAA, 15'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        layouts.push_back(row(15'h2AAA, 15'h5555, 15'h2AAA, 16'h5555, 16'hAAAA, 16'h5555));
        layouts.push_back(row(7000, -3000, 11000, 16'h8000, 16'h8000, 16'h8000));
        for (int n = 0; n < 91; n++)
            layouts.push_back(row(rand_angle(), rand_angle(), rand_angle(),
                                  rand_dim(), rand_dim(), rand_dim()));
    end

    // stimulus side
    initial begin
        t_layout_row L;
        i_rst_n <= 0;
        push <= 0;
        i_yaw_angle <= 0; i_pitch_angle <= 0; i_roll_angle <= 0;
        i_view_distance <= 0; i_screen_width <= 0; i_screen_height <= 0;
        fill_sine_rom();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        #1;
        while (layouts.size() != 0) begin
            @(posedge i_clk);
            if (push && !full) begin
                predict_quad(L);
                void'(layouts.pop_front());
                layouts_sent++;
            end
            if (layouts.size() == 0) begin
                push <= 0;
            end else if (calm || $urandom_range(0, 99) >= 34) begin
                L = layouts[0];
                push <= 1;
                i_yaw_angle <= L.yaw; i_pitch_angle <= L.pitch;
                i_roll_angle <= L.roll; i_view_distance <= L.view_dist;
                i_screen_width <= L.wid; i_screen_height <= L.hei;
            end else begin
                push <= 0;
            end
        end
        send_done = 1;
    end

    // long stretch with no idling in the middle of the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        calm <= (cycles > 300 && cycles < 700);
    end

    // result side
    initial begin
        t_vertex want, got;
        pop <= 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got = '{o_vertex_index, o_pos_x, o_pos_y, o_pos_z,
                        o_tex_u, o_tex_v, o_last_vertex};
                vertices_seen++;
                if (vertex_queue.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected vertex %p", $time, got);
                end else begin
                    want = vertex_queue.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: vertex mismatch expected %p actual %p",
                                 $time, want, got);
                    end
                end
            end
            pop <= calm || ($urandom_range(0, 99) >= 34);
        end
    end

    initial begin
        wait (send_done);
        while (vertex_queue.size() != 0 && cycles < CYCLE_LIMIT)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("sent %0d layouts (axis, wrap-around and extreme sizes plus random)",
                 layouts_sent);
        $display("checked %0d vertices under random stalls on both sides", vertices_seen);
        if (vertex_queue.size() != 0) begin
            errors++;
            $display("%0t: %0d vertices never arrived", $time, vertex_queue.size());
        end
        if (errors == 0) begin
            $display("screen_quad_from_euler_angles_tb: done, clean");
        end else begin
            $display("screen_quad_from_euler_angles_tb: done, errors");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycles == CYCLE_LIMIT + 100) begin
            $display("timeout");
            $display("screen_quad_from_euler_angles_tb: done, errors");
            $finish;
        end
    end

endmodule
